FILE: design/pdc_pkg.sv
// Package with the shared types and constants of the pulse duration clusterer.
package pdc_pkg;

	localparam int DUR_W     = 16;
	localparam int CNT_W     = 8;
	localparam int OIDX_W    = 4;
	localparam int CFG_IDX_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_CLAMP_LIMIT = CFG_IDX_W'(1);

	localparam logic [DUR_W-1:0] TOLERANCE_RST   = DUR_W'(16);
	localparam logic [DUR_W-1:0] CLAMP_LIMIT_RST = '1;
	localparam logic [CNT_W-1:0] CNT_MAX         = '1;

	typedef struct packed {
		logic [DUR_W-1:0] duration;
		logic             level;
		logic             start_new;
	} in_t;

	typedef struct packed {
		logic [OIDX_W-1:0] cluster_index;
		logic              created;
		logic              skipped;
		logic              table_full;
		logic [CNT_W-1:0]  cluster_count;
	} out_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

endpackage

FILE: design/pdc_ram.sv
// Generic single-port-write, registered-read RAM.
module pdc_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: design/pulse_duration_clusterer.sv
// Top level of the pulse duration clusterer: sequencer, match unit and result register.
//
// The block sorts captured IR pulse durations into clusters, with one table for low-level
// periods and one for high-level periods. An incoming duration is clamped to clamp_limit; a
// duration that is then zero is reported as skipped and changes nothing. Otherwise the table
// chosen by level is scanned in index order over its filled entries, and the first stored
// duration v with |v - d| < tolerance is counted again (saturating at 255). Without a match the
// duration is appended with count one, or, when the table holds TABLE_ENTRIES entries already,
// the result reports table_full. A set start_new flag empties both tables before the item is
// handled. Every input transfer produces exactly one output transfer. An item is handled in
// order: it is accepted, the filled entries are read and compared one at a time until the
// match or the end of the table, and the result is handed to the output register. The single
// window compare unit reads the table memory one entry per cycle. The input is stalled for
// the whole time an item is in work; a finished result may wait in the output register while
// the next item is accepted. Both tables share one memory addressed by level and entry number;
// entries beyond the fill count are never read, so the memory needs no clearing after reset.
// Configuration writes are always ready and should be issued only while the block is idle.
module pulse_duration_clusterer #(
	parameter int TABLE_ENTRIES = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  pdc_pkg::in_t                 in_data,
	output logic                         out_valid,
	input  logic                         out_stall,
	output pdc_pkg::out_t                out_data,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [pdc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pdc_pkg::DUR_W-1:0]     cfg_data
);

	import pdc_pkg::*;

	localparam int IDX_W     = $clog2(TABLE_ENTRIES);
	localparam int FILL_W    = $clog2(TABLE_ENTRIES + 1);
	localparam int ADDR_W    = IDX_W + 1;
	localparam int RAM_DEPTH = 2 * (2 ** IDX_W);
	localparam int WORD_W    = DUR_W + CNT_W;

	// Configuration registers.
	logic [DUR_W-1:0] tol_q;
	logic [DUR_W-1:0] clamp_q;

	// Item held during the scan.
	logic [DUR_W-1:0] dur_q;
	logic             lvl_q;

	// Fill count of each table.
	logic [FILL_W-1:0] fill_q [2];

	// Sequencer state.
	state_t            state_q, state_d;
	logic [FILL_W-1:0] rd_idx_q;
	logic              cmp_vld_s1;
	logic [IDX_W-1:0]  cmp_idx_s1;
	out_t              res_q, res_d;

	// Output register.
	logic out_valid_q;
	out_t out_q;

	// Memory ports.
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [WORD_W-1:0] wr_data;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic [WORD_W-1:0] rd_data;

	// Combinational helpers.
	logic              accept;
	logic [DUR_W-1:0]  dur_clamped;
	logic [FILL_W-1:0] cur_fill;
	logic              issue;
	logic              hit;
	logic              scan_end;
	logic [DUR_W-1:0]  stored_dur;
	logic [CNT_W-1:0]  stored_cnt;
	logic [CNT_W-1:0]  next_cnt;
	logic              load_res;
	logic              out_load;
	logic              fill_inc;

	assign cfg_ready = 1'b1;
	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);

	assign dur_clamped = (in_data.duration > clamp_q) ? clamp_q : in_data.duration;

	assign cur_fill   = fill_q[lvl_q];
	assign stored_dur = rd_data[WORD_W-1:CNT_W];
	assign stored_cnt = rd_data[CNT_W-1:0];
	assign next_cnt   = (stored_cnt == CNT_MAX) ? stored_cnt : stored_cnt + CNT_W'(1);

	// The window compare unit. Both sums carry one extra bit so that nothing wraps, and both
	// bounds are strict, so a zero tolerance never matches.
	logic [DUR_W:0] sum_d;
	logic [DUR_W:0] sum_v;
	logic           in_window;

	assign sum_d     = {1'b0, dur_q} + {1'b0, tol_q};
	assign sum_v     = {1'b0, stored_dur} + {1'b0, tol_q};
	assign in_window = (sum_d > {1'b0, stored_dur}) && (sum_v > {1'b0, dur_q});

	assign hit      = (state_q == ST_SCAN) && cmp_vld_s1 && in_window;
	assign issue    = (rd_idx_q < cur_fill);
	assign scan_end = (state_q == ST_SCAN) && !hit && !issue;

	assign rd_en   = (state_q == ST_SCAN) && issue && !hit;
	assign rd_addr = {lvl_q, rd_idx_q[IDX_W-1:0]};

	assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	// Next state, memory writes and the result of the item.
	always_comb begin
		state_d  = state_q;
		res_d    = res_q;
		load_res = 1'b0;
		wr_en    = 1'b0;
		wr_addr  = {lvl_q, cmp_idx_s1};
		wr_data  = {stored_dur, next_cnt};
		fill_inc = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (dur_clamped == '0) begin
						// A zero duration only reports itself as skipped.
						load_res      = 1'b1;
						res_d         = '0;
						res_d.skipped = 1'b1;
						state_d       = ST_DONE;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (hit) begin
					wr_en               = 1'b1;
					load_res            = 1'b1;
					res_d               = '0;
					res_d.cluster_index = OIDX_W'(cmp_idx_s1);
					res_d.cluster_count = next_cnt;
					state_d             = ST_DONE;
				end else if (scan_end) begin
					load_res = 1'b1;
					res_d    = '0;
					if (cur_fill < FILL_W'(TABLE_ENTRIES)) begin
						wr_en               = 1'b1;
						wr_addr             = {lvl_q, cur_fill[IDX_W-1:0]};
						wr_data             = {dur_q, CNT_W'(1)};
						fill_inc            = 1'b1;
						res_d.cluster_index = OIDX_W'(cur_fill[IDX_W-1:0]);
						res_d.created       = 1'b1;
						res_d.cluster_count = CNT_W'(1);
					end else begin
						res_d.table_full = 1'b1;
					end
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q   <= TOLERANCE_RST;
			clamp_q <= CLAMP_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_TOLERANCE) begin
				tol_q <= cfg_data;
			end else if (cfg_index == REG_CLAMP_LIMIT) begin
				clamp_q <= cfg_data;
			end
		end
	end

	// Fill counts: cleared by a start flag at the transfer, bumped on every append.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q[0] <= '0;
			fill_q[1] <= '0;
		end else if (accept && in_data.start_new) begin
			fill_q[0] <= '0;
			fill_q[1] <= '0;
		end else if (fill_inc) begin
			fill_q[lvl_q] <= cur_fill + FILL_W'(1);
		end
	end

	// Scan control: one read issued per cycle, compared the cycle after.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q   <= '0;
			cmp_vld_s1 <= 1'b0;
		end else if (accept) begin
			rd_idx_q   <= '0;
			cmp_vld_s1 <= 1'b0;
		end else begin
			cmp_vld_s1 <= rd_en;
			if (rd_en) begin
				rd_idx_q <= rd_idx_q + FILL_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dur_q <= dur_clamped;
			lvl_q <= in_data.level;
		end
		if (rd_en) begin
			cmp_idx_s1 <= rd_idx_q[IDX_W-1:0];
		end
		if (load_res) begin
			res_q <= res_d;
		end
		if (out_load) begin
			out_q <= res_q;
		end
	end

	// Output register: holds the result until the transfer completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Durations and counts of both tables, addressed by level and entry number.
	pdc_ram #(
		.WIDTH(WORD_W),
		.DEPTH(RAM_DEPTH)
	) u_table (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

endmodule
